// File: rtl/two_stack_insertion_sorter_defines.svh
// Assertion macros used by the checker file.
// Each expects signals clk and rst in scope.
`ifndef TWO_STACK_INSERTION_SORTER_DEFINES_SVH
`define TWO_STACK_INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication.
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tss_pkg.sv
`default_nettype none

package tss_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

endpackage

`default_nettype wire

// File: rtl/two_stack_insertion_sorter.sv
`default_nettype none

// Channel  Dir  Signals                      Contents
// s_*      in   tvalid tready tdata tlast    tdata = value (signed 32); tlast = last
// m_*      out  tvalid tready tdata tlast    tdata = sorted_value (signed 32);
//                tuser                        tlast = final_res; tuser = overflow
//
// Loading accepts one item per cycle while s_tready is high. A batch sorts by
// popping each source entry (ST_POP) and, in ST_CMP, moving every aux entry
// greater than it back to the source stack before pushing it onto aux; moved
// entries are popped again. Each result then goes through a RAM read, an
// output load and a handoff, and waits there while m_tready is low.
// Reset clears counts, overflow flag and control; RAM contents need no clearing.
// s_tready is high only while loading; a stalled m_tready holds the result.

module two_stack_insertion_sorter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [tss_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
  input  wire logic                       s_tlast,   // last
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [tss_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                            m_tlast,   // final_res
  output logic                            m_tuser    // [0] overflow
);

  import tss_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,      // taking items onto the source stack
    ST_POP,       // read source top and aux top
    ST_CMP,       // compare; move one aux entry back or push the held value
    ST_EMIT_RD,   // read aux top for output
    ST_EMIT_LD,   // load output register
    ST_EMIT_WAIT  // wait for downstream
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  src_cnt;
  logic [CNT_W-1:0]  aux_cnt;
  logic              dropped;
  logic              first;   // held value still sits in the source RAM read port
  logic [DATA_W-1:0] cur_q;

  // RAM ports
  logic              src_we;
  logic [ADDR_W-1:0] src_waddr;
  logic [DATA_W-1:0] src_wdata;
  logic [ADDR_W-1:0] src_raddr;
  logic [DATA_W-1:0] src_rdata;
  logic              aux_we;
  logic [ADDR_W-1:0] aux_waddr;
  logic [DATA_W-1:0] aux_wdata;
  logic [ADDR_W-1:0] aux_raddr;
  logic [DATA_W-1:0] aux_rdata;

  logic [CNT_W-1:0]  src_cnt_m1;
  logic [CNT_W-1:0]  aux_cnt_m1;
  logic [CNT_W-1:0]  aux_cnt_m2;
  logic [DATA_W-1:0] cur_val;
  logic              move;
  logic              src_full;

  assign src_cnt_m1 = src_cnt - CNT_ONE;
  assign aux_cnt_m1 = aux_cnt - CNT_ONE;
  assign aux_cnt_m2 = aux_cnt - CNT_TWO;
  assign src_full   = (src_cnt >= CNT_FULL);
  assign cur_val    = first ? src_rdata : cur_q;
  // aux top strictly greater than the held value goes back to the source stack
  assign move       = (aux_cnt != '0) && ($signed(aux_rdata) > $signed(cur_val));

  assign s_tready = (state == ST_LOAD);

  always_comb begin
    src_we    = 1'b0;
    src_waddr = src_cnt[ADDR_W-1:0];
    src_wdata = aux_rdata;
    src_raddr = src_cnt_m1[ADDR_W-1:0];
    aux_we    = 1'b0;
    aux_waddr = aux_cnt[ADDR_W-1:0];
    aux_wdata = cur_val;
    aux_raddr = aux_cnt_m1[ADDR_W-1:0];
    unique case (state)
      ST_LOAD: begin
        src_we    = s_tvalid && !src_full;
        src_wdata = s_tdata;
      end
      ST_CMP: begin
        src_we = move;
        aux_we = !move;
        if (move) begin
          aux_raddr = aux_cnt_m2[ADDR_W-1:0];  // next aux top after this move
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      src_cnt  <= '0;
      aux_cnt  <= '0;
      dropped  <= 1'b0;
      first    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            if (src_full) begin
              dropped <= 1'b1;
            end else begin
              src_cnt <= src_cnt + CNT_ONE;
            end
            if (s_tlast) begin
              state <= ST_POP;
            end
          end
        end
        ST_POP: begin
          src_cnt <= src_cnt_m1;
          first   <= 1'b1;
          state   <= ST_CMP;
        end
        ST_CMP: begin
          first <= 1'b0;
          cur_q <= cur_val;
          if (move) begin
            src_cnt <= src_cnt + CNT_ONE;
            aux_cnt <= aux_cnt_m1;
          end else begin
            aux_cnt <= aux_cnt + CNT_ONE;
            state   <= (src_cnt != '0) ? ST_POP : ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          aux_cnt <= aux_cnt_m1;
          state   <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          m_tdata  <= aux_rdata;
          m_tlast  <= (aux_cnt == '0);
          m_tuser  <= dropped;
          m_tvalid <= 1'b1;
          state    <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              src_cnt <= '0;
              aux_cnt <= '0;
              dropped <= 1'b0;
              state   <= ST_LOAD;
            end else begin
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  tss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  tss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_aux_ram (
    .clk   (clk),
    .we    (aux_we),
    .waddr (aux_waddr),
    .wdata (aux_wdata),
    .raddr (aux_raddr),
    .rdata (aux_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/tss_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/tss_checker.sv
`default_nettype none

`include "two_stack_insertion_sorter_defines.svh"

module tss_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       s_tlast,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [tss_pkg::DATA_W-1:0] m_tdata,
  input wire logic                       m_tlast,
  input wire logic                       m_tuser
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // stalled result holds
  `TSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
  // loading and emitting never overlap
  `TSS_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input ready while result pending")
  // batch end stops intake
  `TSS_ASSERT_NEXT(a_last_stops, in_acc && s_tlast, !s_tready, "intake continued after batch end")
  // final result reopens intake
  `TSS_ASSERT_NEXT(a_final_reopens, out_acc && m_tlast, s_tready, "intake not reopened after batch")
  // overflow flag constant across a batch
  `TSS_ASSERT_NEXT(a_ovf_steady, out_acc && !m_tlast, $stable(m_tuser), "overflow flag changed mid-batch")

endmodule

bind two_stack_insertion_sorter tss_checker u_tss_checker (.*);

`default_nettype wire

// File: verif/two_stack_insertion_sorter_tb.sv
`default_nettype none

module two_stack_insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::DEPTH;
  import tss_pkg::DATA_W;

  typedef logic signed [DATA_W-1:0] value_t;

  // One sorted output item, in the order the m_* side presents it
  typedef struct packed {
    value_t sorted_value;
    logic   final_res;
    logic   overflow;
  } result_t;

  // Directed row. Where typed is set, the row is a single-value batch on an
  // empty source stack, so the only result is the value itself.
  typedef struct packed {
    value_t value;
    logic   last;
    logic   typed;
    value_t exp_value;
  } stim_row_t;

  localparam value_t VAL_MAX     = value_t'(32'h7fff_ffff);
  localparam value_t VAL_MIN     = value_t'(32'h8000_0000);
  localparam int     N_DIR       = 17;
  localparam int     PHASE_ITEMS = 80;   // random items per idling phase
  localparam int     TAIL_CYCLES = 200;  // quiet time after the last result

  logic   clk;
  logic   rst      = 1'b1;
  logic   s_tvalid = 1'b0;
  logic   s_tready;
  value_t s_tdata  = '0;
  logic   s_tlast  = 1'b0;
  logic   m_tvalid;
  logic   m_tready = 1'b0;
  value_t m_tdata;
  logic   m_tlast;
  logic   m_tuser;

  two_stack_insertion_sorter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] value
    .s_tlast  (s_tlast),   // last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] sorted_value
    .m_tlast  (m_tlast),   // final_res
    .m_tuser  (m_tuser)    // [0] overflow
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: shadow source stack and dropped-push flag. On a last item the
  // batch is sorted with the same two-stack insertion scheme and the results
  // land in sorted_q, largest first.
  // --------------------------------------------------------------------------
  value_t  src_q[$];
  bit      dropped;
  result_t sorted_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int n_items;
  int n_batches;
  int n_ovf_batches;
  int n_results;
  int mismatches;

  // Hard stop: far beyond the worst batch's sort plus 64 results under stall,
  // and beyond the whole run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $display("timeout: %0d results still outstanding", sorted_q.size());
    $finish;
  end

  function automatic void load_value(value_t v, logic last);
    value_t aux_q[$];
    value_t cur;
    // full source stack: push is lost, batch is marked
    if (src_q.size() < DEPTH) src_q.push_back(v);
    else dropped = 1'b1;
    if (!last) return;
    while (src_q.size() > 0) begin
      cur = src_q.pop_back();
      // only strictly greater entries move back, so ties keep their order
      while (aux_q.size() > 0 && aux_q[$] > cur) src_q.push_back(aux_q.pop_back());
      aux_q.push_back(cur);
    end
    // aux top is the largest entry; empty it top to bottom
    while (aux_q.size() > 0) begin
      cur = aux_q.pop_back();
      sorted_q.push_back('{cur, (aux_q.size() == 0), dropped});
    end
    n_batches++;
    if (dropped) n_ovf_batches++;
    dropped = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge (or right after reset). A gap lowers
  // tvalid for as long as the random idle draw asks; with no gap the next item follows at once,
  // so tvalid only ever gets one nonblocking update per edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input value_t v, input logic last,
                           input logic typed = 1'b0, input value_t typed_exp = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (typed) begin
      sorted_q.push_back('{typed_exp, 1'b1, 1'b0});
      n_batches++;
    end else begin
      load_value(v, last);
    end
  endtask

  // Batch shapes: random, few distinct values (lots of ties), rising ramp
  // (most moves back), falling ramp, and field extremes.
  task automatic send_batch(input int n);
    value_t base;
    value_t v;
    int     shape;
    base  = value_t'($urandom);
    shape = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: v = value_t'($urandom);
        1: v = value_t'($urandom_range(6)) - 3;
        2: v = base + i;
        3: v = base - i;
        default: begin
          case ($urandom_range(3))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2: v = '0;
            default: v = '1;
          endcase
        end
      endcase
      send_item(v, (i == n - 1));
    end
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic drain;
    s_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted item against the oldest prediction, then
  // picks tready for the next edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tlast, m_tuser};
        n_results++;
        if (sorted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item value=%0d last=%0b ovf=%0b",
                     $realtime, got.sorted_value, got.final_res, got.overflow);
        end else begin
          want = sorted_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                       $realtime, want.sorted_value, want.final_res, want.overflow,
                       got.sorted_value, got.final_res, got.overflow);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Directed part: single-value batches at the extremes, zero and -1 (result read off
  // directly), then a batch with ties and both extremes, a rising run that
  // forces the most moves back, and a falling run that needs none.
  stim_row_t dir_rows [0:N_DIR-1] = '{
    '{VAL_MAX,     1'b1, 1'b1, VAL_MAX},
    '{VAL_MIN,     1'b1, 1'b1, VAL_MIN},
    '{32'sd0,      1'b1, 1'b1, 32'sd0},
    '{-32'sd1,     1'b1, 1'b1, -32'sd1},
    '{32'sd5,      1'b0, 1'b0, 32'sd0},
    '{-32'sd3,     1'b0, 1'b0, 32'sd0},
    '{VAL_MAX,     1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,     1'b0, 1'b0, 32'sd0},
    '{32'sd5,      1'b1, 1'b0, 32'sd0},
    '{32'sd1,      1'b0, 1'b0, 32'sd0},
    '{32'sd2,      1'b0, 1'b0, 32'sd0},
    '{32'sd3,      1'b0, 1'b0, 32'sd0},
    '{32'sd4,      1'b1, 1'b0, 32'sd0},
    '{32'sd40,     1'b0, 1'b0, 32'sd0},
    '{32'sd30,     1'b0, 1'b0, 32'sd0},
    '{-32'sd20,    1'b0, 1'b0, 32'sd0},
    '{-32'sd30,    1'b1, 1'b0, 32'sd0}
  };

  // One long batch per phase: just over full (the last-marked value itself is
  // dropped), exactly full, and four over.
  int big_size [0:2] = '{DEPTH + 1, DEPTH, DEPTH + 4};

  initial begin
    int start_items;
    tx_idle_pct = 25;
    rx_idle_pct = 60;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++)
      send_item(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].exp_value);
    drain();

    // Phases: sender-light/receiver-heavy, the reverse, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 25 : 0;
      start_items = n_items;
      send_batch(big_size[ph]);
      while (n_items - start_items < PHASE_ITEMS)
        send_batch(($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += sorted_q.size();
    $display("%0d values sent in %0d batches (%0d with dropped pushes), %0d sorted items checked",
             n_items, n_batches, n_ovf_batches, n_results);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: two_stack_insertion_sorter.f
+incdir+rtl
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/two_stack_insertion_sorter.sv
rtl/tss_checker.sv
verif/two_stack_insertion_sorter_tb.sv
